>>> rtl/modexp_pkg.sv
package modexp_pkg;

	localparam int unsigned MOD_WIDTH = 32;
	localparam int unsigned EXP_WIDTH = 64;
	localparam int unsigned BIT_CNT_W = $clog2(MOD_WIDTH + 1);

	typedef logic [MOD_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MULT,
		ST_DONE
	} state_t;

	// one step of the MSB-first interleaved modular multiply: r' = (2r + bit*a) mod m
	function automatic word_t mm_step(word_t r, word_t a, logic bit_in, word_t m);
		logic [MOD_WIDTH+1:0] t;
		begin
			t = {2'b00, r} << 1;
			if (t >= {2'b00, m}) t = t - {2'b00, m};
			if (bit_in) t = t + {2'b00, a};
			if (t >= {2'b00, m}) t = t - {2'b00, m};
			return t[MOD_WIDTH-1:0];
		end
	endfunction

endpackage

>>> rtl/modexp_cell.sv
// One cell of the multiplier row: holds the running remainder of one product
// and folds in one multiplier bit per cycle while step is high.
module modexp_cell (
	input  logic                   clk,
	input  logic                   clear,
	input  logic                   step,
	input  modexp_pkg::word_t      mcand,
	input  logic                   mbit,
	input  modexp_pkg::word_t      modulus,
	output modexp_pkg::word_t      rem
);

	modexp_pkg::word_t rem_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			rem_q <= '0;
		end else if (step) begin
			rem_q <= modexp_pkg::mm_step(rem_q, mcand, mbit, modulus);
		end
	end

	assign rem = rem_q;

endmodule

>>> rtl/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply.
// Input: pulse start with base_value, exponent and modulus while busy is low;
// the item is captured on that edge and busy rises at once.
// Output: power_result is shown for exactly one cycle with done high; the
// receiver cannot stall it, so no back-pressure exists.
// Flow: the base is first reduced mod modulus (a multiply of one by the base
// bits, MSB first). Each exponent bit then takes a setup state (ST_BIT) and
// a multiply state (ST_MULT) in which two cells run side by side: the
// square cell (b*b mod m) and the product cell (acc*b mod m), each folding one
// multiplier bit per cycle through a shift, add and two conditional subtracts.
// The loop stops early once the remaining exponent is 0.
// An exponent of zero (result 1) or a modulus of zero (result 0) skips the
// loop: the reduce state sets the result and goes straight to the done
// state.
// Items: one at a time; busy stays high through the done cycle, so a new
// start is taken only once the controller is back in idle.
// Reset: arst_n clears the controller to idle; no result is pending.
module modular_exponentiation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] base_value,
	input  logic [63:0] exponent,
	input  logic [31:0] modulus,
	output logic        done,
	output logic [31:0] power_result
);

	localparam int unsigned MW = modexp_pkg::MOD_WIDTH;
	localparam int unsigned EW = modexp_pkg::EXP_WIDTH;

	modexp_pkg::state_t state_q, state_d;

	modexp_pkg::word_t mod_q, base_q, acc_q, res_q;
	logic [EW-1:0]                    exp_q;
	logic [modexp_pkg::BIT_CNT_W-1:0] cnt_q;
	logic                             zero_exp_q;
	logic                             use_mul_q;

	// cell controls
	logic cell_clear, cell_step;
	modexp_pkg::word_t sq_rem, pr_rem;
	modexp_pkg::word_t sq_mcand, pr_mcand;
	logic sq_bit, pr_bit;
	logic [$clog2(MW)-1:0] bit_idx;

	assign bit_idx = cnt_q[$clog2(MW)-1:0];

	// during reduction, square cell computes 1*base mod m, base bits as multiplier
	always_comb begin
		if (state_q == modexp_pkg::ST_REDUCE) begin
			sq_mcand = modexp_pkg::word_t'(1);
			sq_bit   = base_q[bit_idx];
		end else begin
			sq_mcand = base_q;
			sq_bit   = base_q[bit_idx];
		end
		pr_mcand = acc_q;
		pr_bit   = base_q[bit_idx];
	end

	modexp_cell u_sq (
		.clk(clk), .clear(cell_clear), .step(cell_step),
		.mcand(sq_mcand), .mbit(sq_bit), .modulus(mod_q), .rem(sq_rem)
	);

	modexp_cell u_pr (
		.clk(clk), .clear(cell_clear), .step(cell_step),
		.mcand(pr_mcand), .mbit(pr_bit), .modulus(mod_q), .rem(pr_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			modexp_pkg::ST_IDLE:   if (start) state_d = modexp_pkg::ST_REDUCE;
			modexp_pkg::ST_REDUCE: begin
				if (zero_exp_q || mod_q == '0) state_d = modexp_pkg::ST_DONE;
				else if (cnt_q == '0) state_d = modexp_pkg::ST_BIT;
			end
			modexp_pkg::ST_BIT: begin
				if (exp_q == '0) state_d = modexp_pkg::ST_DONE;
				else state_d = modexp_pkg::ST_MULT;
			end
			modexp_pkg::ST_MULT:   if (cnt_q == '0) state_d = modexp_pkg::ST_BIT;
			modexp_pkg::ST_DONE:   state_d = modexp_pkg::ST_IDLE;
			default:               state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy       = (state_q != modexp_pkg::ST_IDLE);
		done       = (state_q == modexp_pkg::ST_DONE);
		cell_step  = (state_q == modexp_pkg::ST_REDUCE) || (state_q == modexp_pkg::ST_MULT);
		cell_clear = (state_q == modexp_pkg::ST_IDLE) || (state_q == modexp_pkg::ST_BIT);
		power_result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: cnt counts down MOD_WIDTH-1..0 over multiplier bits, MSB first
	always_ff @(posedge clk) begin
		unique case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (start) begin
					base_q     <= base_value[MW-1:0];
					exp_q      <= exponent[EW-1:0];
					mod_q      <= modulus[MW-1:0];
					zero_exp_q <= (exponent[EW-1:0] == '0);
					cnt_q      <= modexp_pkg::BIT_CNT_W'(MW - 1);
				end
			end
			modexp_pkg::ST_REDUCE: begin
				cnt_q <= cnt_q - 1'b1;
				if (zero_exp_q || mod_q == '0) begin
					// zero exponent gives 1 even for modulus one; zero modulus gives 0
					res_q <= zero_exp_q ? modexp_pkg::word_t'(1) : '0;
				end else if (cnt_q == '0) begin
					// sq_rem not yet updated with last step; take step result directly
					base_q <= modexp_pkg::mm_step(sq_rem, sq_mcand, sq_bit, mod_q);
					// acc = 1 mod m
					acc_q  <= (mod_q == modexp_pkg::word_t'(1)) ? '0 : modexp_pkg::word_t'(1);
				end
			end
			modexp_pkg::ST_BIT: begin
				cnt_q     <= modexp_pkg::BIT_CNT_W'(MW - 1);
				use_mul_q <= exp_q[0];
				if (exp_q == '0) res_q <= acc_q;
			end
			modexp_pkg::ST_MULT: begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					base_q <= modexp_pkg::mm_step(sq_rem, sq_mcand, sq_bit, mod_q);
					if (use_mul_q)
						acc_q <= modexp_pkg::mm_step(pr_rem, pr_mcand, pr_bit, mod_q);
					exp_q <= exp_q >> 1;
				end
			end
			modexp_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
